### rtl/battery_voltage_window_average_defines.svh
// ----------------------------------------------------------------------------
// Battery voltage window average: assertion macros
// Shared concurrent assertion forms, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef BATTERY_VOLTAGE_WINDOW_AVERAGE_DEFINES_SVH
`define BATTERY_VOLTAGE_WINDOW_AVERAGE_DEFINES_SVH

// Assertion that is off while reset is held.
`define BVWA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is checked in every cycle, reset included.
`define BVWA_ASSERT_ALL(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/bvwa_pkg.sv
// ----------------------------------------------------------------------------
// bvwa_pkg
// Constants, types and register codes of the battery voltage window average.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bvwa_pkg;

  localparam int WINDOW_SIZE   = 8;
  localparam int SCALE_DIVISOR = 1024;
  localparam int DISPLAY_STEP  = 100;
  localparam int ADC_BITS      = 12;

  localparam int VOLT_W   = 16;
  localparam int DISP_W   = 8;
  localparam int GAIN_W   = 16;
  localparam int OFFS_W   = 8;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 3;

  localparam int SLOT_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int TOTAL_W = VOLT_W + $clog2(WINDOW_SIZE);
  localparam int PROD_W  = ADC_BITS + GAIN_W;

  // floor(x / DISPLAY_STEP) == (x * RECIP) >> RECIP_SHIFT for every 16-bit x
  localparam int    RECIP_SHIFT = VOLT_W + $clog2(DISPLAY_STEP);
  localparam int    RECIP_W     = VOLT_W + 1;
  localparam longint RECIP_VAL  =
    ((longint'(1) << RECIP_SHIFT) + longint'(DISPLAY_STEP) - 1) / longint'(DISPLAY_STEP);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_SIZE - 1);
  localparam logic [VOLT_W-1:0] VOLT_SAT  = '1;

  localparam logic [GAIN_W-1:0] SCALE_GAIN_RST     = GAIN_W'(1);
  localparam logic [VOLT_W-1:0] VOLT_MIN_RST       = '0;
  localparam logic [VOLT_W-1:0] VOLT_MAX_RST       = '1;
  localparam logic [VOLT_W-1:0] HYSTERESIS_RST     = '0;
  localparam logic [VOLT_W-1:0] INIT_VALUE_RST     = '0;
  localparam logic [OFFS_W-1:0] DISPLAY_OFFSET_RST = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_GAIN     = 3'd0,
    REG_VOLT_MIN       = 3'd1,
    REG_VOLT_MAX       = 3'd2,
    REG_HYSTERESIS     = 3'd3,
    REG_INIT_VALUE     = 3'd4,
    REG_DISPLAY_OFFSET = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0] scale_gain;
    logic [VOLT_W-1:0] volt_min;
    logic [VOLT_W-1:0] volt_max;
    logic [VOLT_W-1:0] hysteresis;
    logic [VOLT_W-1:0] init_value;
    logic [OFFS_W-1:0] display_offset;
  } cfg_t;

  typedef struct packed {
    logic              ign;
    logic [VOLT_W-1:0] volt;
  } sample_t;

endpackage

### rtl/bvwa_if.sv
// ----------------------------------------------------------------------------
// bvwa_in_if / bvwa_out_if
// Valid/ready channels for sample beats and result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bvwa_in_if import bvwa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                ignition_on;
  logic                adc_ok;
  logic [ADC_BITS-1:0] adc_raw;

  modport source (output valid, output ignition_on, output adc_ok, output adc_raw,
                  input ready);
  modport sink   (input valid, input ignition_on, input adc_ok, input adc_raw,
                  output ready);
endinterface

interface bvwa_out_if import bvwa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VOLT_W-1:0] voltage_value;
  logic [DISP_W-1:0] display_value;

  modport source (output valid, output voltage_value, output display_value,
                  input ready);
  modport sink   (input valid, input voltage_value, input display_value,
                  output ready);
endinterface

### rtl/bvwa_cfg.sv
// ----------------------------------------------------------------------------
// bvwa_cfg
// Configuration register file, written by index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bvwa_cfg import bvwa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_SCALE_GAIN:     cfg_nxt.scale_gain     = cfg_wdata[GAIN_W-1:0];
        REG_VOLT_MIN:       cfg_nxt.volt_min       = cfg_wdata[VOLT_W-1:0];
        REG_VOLT_MAX:       cfg_nxt.volt_max       = cfg_wdata[VOLT_W-1:0];
        REG_HYSTERESIS:     cfg_nxt.hysteresis     = cfg_wdata[VOLT_W-1:0];
        REG_INIT_VALUE:     cfg_nxt.init_value     = cfg_wdata[VOLT_W-1:0];
        REG_DISPLAY_OFFSET: cfg_nxt.display_offset = cfg_wdata[OFFS_W-1:0];
        default:            cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale_gain     <= SCALE_GAIN_RST;
      cfg_r.volt_min       <= VOLT_MIN_RST;
      cfg_r.volt_max       <= VOLT_MAX_RST;
      cfg_r.hysteresis     <= HYSTERESIS_RST;
      cfg_r.init_value     <= INIT_VALUE_RST;
      cfg_r.display_offset <= DISPLAY_OFFSET_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/bvwa_scale.sv
// ----------------------------------------------------------------------------
// bvwa_scale
// Input register and scaling stage: gain multiply, divide, saturate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bvwa_scale import bvwa_pkg::*; (
  input  logic                clk,
  input  logic                load_in,
  input  logic                load_smp,
  input  logic                ignition_on,
  input  logic                adc_ok,
  input  logic [ADC_BITS-1:0] adc_raw,
  input  cfg_t                cfg,
  output sample_t             smp
);

  logic                ign_r;
  logic                ok_r;
  logic [ADC_BITS-1:0] raw_r;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   scaled;
  logic [VOLT_W-1:0]   sat;
  sample_t             smp_r;
  sample_t             smp_nxt;

  assign prod   = {{GAIN_W{1'b0}}, raw_r} * {{ADC_BITS{1'b0}}, cfg.scale_gain};
  assign scaled = PROD_W'(prod / SCALE_DIVISOR);
  assign sat    = (scaled > PROD_W'(VOLT_SAT)) ? VOLT_SAT : scaled[VOLT_W-1:0];

  always_comb begin
    smp_nxt.ign  = ign_r;
    smp_nxt.volt = ok_r ? sat : cfg.volt_min;
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      ign_r <= ignition_on;
      ok_r  <= adc_ok;
      raw_r <= adc_raw;
    end
    if (load_smp) begin
      smp_r <= smp_nxt;
    end
  end

  assign smp = smp_r;

endmodule

### rtl/bvwa_window.sv
// ----------------------------------------------------------------------------
// bvwa_window
// Ring window with running total, hysteresis hold and clamp of the average.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bvwa_window import bvwa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  sample_t           smp,
  input  cfg_t              cfg,
  output logic [VOLT_W-1:0] held
);

  logic [VOLT_W-1:0]  win_r [WINDOW_SIZE];
  logic [SLOT_W-1:0]  slot_r;
  logic [SLOT_W-1:0]  slot_nxt;
  logic [TOTAL_W-1:0] total_r;
  logic [TOTAL_W-1:0] total_nxt;
  logic [VOLT_W-1:0]  held_r;
  logic [VOLT_W-1:0]  held_nxt;
  logic [TOTAL_W-1:0] avg_full;
  logic [VOLT_W-1:0]  avg;
  logic [VOLT_W-1:0]  diff;
  logic [VOLT_W-1:0]  cand;

  always_comb begin
    total_nxt = total_r - TOTAL_W'(win_r[slot_r]) + TOTAL_W'(smp.volt);
    slot_nxt  = (slot_r == SLOT_LAST) ? '0 : slot_r + SLOT_W'(1);
    avg_full  = TOTAL_W'(total_nxt / WINDOW_SIZE);
    avg       = avg_full[VOLT_W-1:0];
    diff      = (avg > held_r) ? (avg - held_r) : (held_r - avg);
    cand      = (diff <= cfg.hysteresis) ? held_r : avg;
    if (cand >= cfg.volt_max) begin
      held_nxt = cfg.volt_max;
    end else if (cand <= cfg.volt_min) begin
      held_nxt = cfg.volt_min;
    end else begin
      held_nxt = cand;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_SIZE; i++) begin
        win_r[i] <= '0;
      end
      slot_r  <= '0;
      total_r <= '0;
      held_r  <= INIT_VALUE_RST;
    end else if (load) begin
      if (smp.ign) begin
        win_r[slot_r] <= smp.volt;
        slot_r        <= slot_nxt;
        total_r       <= total_nxt;
        held_r        <= held_nxt;
      end else begin
        for (int i = 0; i < WINDOW_SIZE; i++) begin
          win_r[i] <= '0;
        end
        slot_r  <= '0;
        total_r <= '0;
        held_r  <= cfg.init_value;
      end
    end
  end

  assign held = held_r;

endmodule

### rtl/battery_voltage_window_average.sv
// ----------------------------------------------------------------------------
// battery_voltage_window_average
// Scaled ADC samples averaged over a ring window, held with hysteresis and
// clamped, with a display byte alongside.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one sample beat (ignition_on, adc_ok, adc_raw); out_ch
//   returns one result beat (voltage_value, display_value) per sample beat,
//   in order. cfg_wr_en/cfg_addr/cfg_wdata write the six setup registers;
//   write them only while no beat is in flight.
//   The path is four register stages: input, scaled sample, window/held
//   voltage, output. With out_ch.ready high one sample is taken each cycle.
//   Each stage advances when the next one is empty or is emptying, so
//   in_ch.ready stays high while bubbles remain even when a result waits.
//   When the receiver stalls, the pipeline fills and in_ch.ready drops
//   after at most four further beats.
//   Reset empties the pipeline, loads the register defaults, clears the
//   window and sets the held voltage to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module battery_voltage_window_average import bvwa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  bvwa_in_if.sink              in_ch,
  bvwa_out_if.source           out_ch,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t                       cfg;
  sample_t                    smp;
  logic [VOLT_W-1:0]          held;
  logic                       s1_v_r;
  logic                       s2_v_r;
  logic                       s3_v_r;
  logic                       out_v_r;
  logic                       out_free;
  logic                       s3_free;
  logic                       s2_free;
  logic                       s1_free;
  logic                       load_in;
  logic                       load_smp;
  logic                       load_win;
  logic                       load_out;
  logic [VOLT_W+RECIP_W-1:0]  disp_prod;
  logic [VOLT_W-1:0]          quot;
  logic [VOLT_W-1:0]          out_volt_r;
  logic [VOLT_W-1:0]          out_quot_r;

  bvwa_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bvwa_scale u_scale (
    .clk         (clk),
    .load_in     (load_in),
    .load_smp    (load_smp),
    .ignition_on (in_ch.ignition_on),
    .adc_ok      (in_ch.adc_ok),
    .adc_raw     (in_ch.adc_raw),
    .cfg         (cfg),
    .smp         (smp)
  );

  bvwa_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (load_win),
    .smp   (smp),
    .cfg   (cfg),
    .held  (held)
  );

  // advance each stage when the next one is empty or emptying
  assign out_free = !out_v_r || out_ch.ready;
  assign s3_free  = !s3_v_r || out_free;
  assign s2_free  = !s2_v_r || s3_free;
  assign s1_free  = !s1_v_r || s2_free;

  assign load_in  = in_ch.valid && s1_free;
  assign load_smp = s1_v_r && s2_free;
  assign load_win = s2_v_r && s3_free;
  assign load_out = s3_v_r && out_free;

  assign in_ch.ready = s1_free;

  assign disp_prod = {{RECIP_W{1'b0}}, held} * {{VOLT_W{1'b0}}, RECIP};
  assign quot      = VOLT_W'(disp_prod >> RECIP_SHIFT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_free)  s1_v_r  <= in_ch.valid;
      if (s2_free)  s2_v_r  <= s1_v_r;
      if (s3_free)  s3_v_r  <= s2_v_r;
      if (out_free) out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_volt_r <= held;
      out_quot_r <= quot;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.voltage_value = out_volt_r;
  assign out_ch.display_value = out_quot_r[DISP_W-1:0] - cfg.display_offset;

endmodule

### rtl/bvwa_checker.sv
// ----------------------------------------------------------------------------
// bvwa_checker
// Port-level checks of the battery voltage window average, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "battery_voltage_window_average_defines.svh"

module bvwa_checker import bvwa_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [VOLT_W-1:0] out_voltage,
  input logic [DISP_W-1:0] out_display
);

  logic                     out_stall;
  logic [VOLT_W+DISP_W-1:0] out_beat;

  assign out_stall = out_valid && !out_ready;
  assign out_beat  = {out_voltage, out_display};

  `BVWA_ASSERT_ALL(a_reset_empty, !rst_n |=> !out_valid, "result beat right after reset")

  `BVWA_ASSERT(a_empty_takes, !out_valid |-> in_ready, "sample refused with empty output")

  `BVWA_ASSERT(a_stall_hold, out_stall |=> out_valid && $stable(out_beat), "stalled beat changed")

  `BVWA_ASSERT(a_take_fills, in_valid && out_ready |-> in_ready, "sample refused while draining")

endmodule

bind battery_voltage_window_average bvwa_checker u_bvwa_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_voltage (out_ch.voltage_value),
  .out_display (out_ch.display_value)
);
